FILE: sv/rc4_keystream_xor_sum_unit_assert.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low.
`ifndef RC4_KEYSTREAM_XOR_SUM_UNIT_ASSERT_SVH
`define RC4_KEYSTREAM_XOR_SUM_UNIT_ASSERT_SVH

// same-cycle implication
`define RC4KS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RC4KS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rc4ks_pkg.sv
`timescale 1ns / 1ps
package rc4ks_pkg;

  localparam int unsigned KEY_LENGTH = 19;
  localparam int unsigned PHRASE_LEN = 19;
  localparam logic [8*PHRASE_LEN-1:0] KEY_PHRASE = "prettygoodkeyphrase";

  localparam int unsigned SBOX_DEPTH = 256;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned SUM_W      = 32;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,   // capture word, clear indices and sum
    OP_CAP,     // capture word
    OP_INIT,    // S[i] = i
    OP_K1,
    OP_K2,
    OP_K3,
    OP_K4,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_P5,
    OP_P6
  } op_e;

  typedef struct packed {
    op_e  op;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_last;  // i == 255
    logic last;      // captured word is final
  } sts_t;

  // key ROM; positions past the phrase read as zero
  function automatic logic [7:0] key_byte(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (int'(idx) < PHRASE_LEN) begin
      b = KEY_PHRASE[8*(PHRASE_LEN-1-int'(idx)) +: 8];
    end
    return b;
  endfunction

endpackage

FILE: sv/rc4ks_ram.sv
`timescale 1ns / 1ps
module rc4ks_ram #(
  parameter int unsigned Width = rc4ks_pkg::BYTE_W,
  parameter int unsigned Depth = rc4ks_pkg::SBOX_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/rc4ks_dp.sv
`timescale 1ns / 1ps
module rc4ks_dp #(
  parameter int unsigned KeyLength = rc4ks_pkg::KEY_LENGTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rc4ks_pkg::cmd_t             cmd_i,
  input  logic [7:0]                  byte_i,
  input  logic                        last_i,
  output rc4ks_pkg::sts_t             sts_o,
  output logic [rc4ks_pkg::SUM_W-1:0] checksum_o
);

  logic [7:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [7:0] si_q, si_d, sj_q, sj_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic [rc4ks_pkg::SUM_W-1:0] sum_q, sum_d, out_q, sum_next;

  logic       we;
  logic [7:0] waddr, wdata, raddr, rdata;
  logic [7:0] acc;

  rc4ks_ram #(
    .Width(rc4ks_pkg::BYTE_W),
    .Depth(rc4ks_pkg::SBOX_DEPTH)
  ) u_sbox (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign acc      = j_q + rdata + rc4ks_pkg::key_byte(k_q);
  assign sum_next = sum_q + {24'h000000, byte_q ^ rdata};

  always_comb begin
    i_d   = i_q;
    j_d   = j_q;
    k_d   = k_q;
    si_d  = si_q;
    sj_d  = sj_q;
    sum_d = sum_q;
    we    = 1'b0;
    waddr = i_q;
    wdata = rdata;
    raddr = i_q;
    case (cmd_i.op)
      rc4ks_pkg::OP_START: begin
        i_d   = 8'h00;
        j_d   = 8'h00;
        k_d   = 8'h00;
        sum_d = '0;
      end
      rc4ks_pkg::OP_INIT: begin
        we    = 1'b1;
        wdata = i_q;
        i_d   = i_q + 8'h01;
      end
      rc4ks_pkg::OP_K1: begin
        raddr = i_q;
      end
      rc4ks_pkg::OP_K2: begin
        si_d  = rdata;
        j_d   = acc;
        raddr = acc;
      end
      rc4ks_pkg::OP_K3, rc4ks_pkg::OP_P3: begin
        sj_d  = rdata;
        we    = 1'b1;
        waddr = i_q;
        wdata = rdata;
      end
      rc4ks_pkg::OP_K4: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        i_d   = i_q + 8'h01;
        k_d   = (k_q == 8'(KeyLength - 1)) ? 8'h00 : k_q + 8'h01;
        // schedule done: generation starts from j = 0
        if (i_q == 8'hff) begin
          j_d = 8'h00;
        end
      end
      rc4ks_pkg::OP_P1: begin
        i_d   = i_q + 8'h01;
        raddr = i_q + 8'h01;
      end
      rc4ks_pkg::OP_P2: begin
        si_d  = rdata;
        j_d   = j_q + rdata;
        raddr = j_q + rdata;
      end
      rc4ks_pkg::OP_P4: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
      end
      rc4ks_pkg::OP_P5: begin
        // S[i] + S[j] after the swap equals the pre-swap sum
        raddr = si_q + sj_q;
      end
      rc4ks_pkg::OP_P6: begin
        sum_d = sum_next;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q   <= '0;
      j_q   <= '0;
      k_q   <= '0;
      sum_q <= '0;
    end else begin
      i_q   <= i_d;
      j_q   <= j_d;
      k_q   <= k_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q <= si_d;
    sj_q <= sj_d;
    if (cmd_i.op == rc4ks_pkg::OP_START || cmd_i.op == rc4ks_pkg::OP_CAP) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
    if (cmd_i.load_out) begin
      out_q <= sum_next;
    end
  end

  assign sts_o.cnt_last = (i_q == 8'hff);
  assign sts_o.last     = last_q;
  assign checksum_o     = out_q;

endmodule

FILE: sv/rc4ks_ctrl.sv
`timescale 1ns / 1ps
`include "rc4_keystream_xor_sum_unit_assert.svh"
module rc4ks_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  input  logic            m_ready_i,
  output logic            m_valid_o,
  input  rc4ks_pkg::sts_t sts_i,
  output rc4ks_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_K1   = 4'd2;
  localparam logic [3:0] ST_K2   = 4'd3;
  localparam logic [3:0] ST_K3   = 4'd4;
  localparam logic [3:0] ST_K4   = 4'd5;
  localparam logic [3:0] ST_P1   = 4'd6;
  localparam logic [3:0] ST_P2   = 4'd7;
  localparam logic [3:0] ST_P3   = 4'd8;
  localparam logic [3:0] ST_P4   = 4'd9;
  localparam logic [3:0] ST_P5   = 4'd10;
  localparam logic [3:0] ST_P6   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       in_msg_q, in_msg_d;
  logic       out_valid_q, out_valid_d;
  logic       accept, out_busy, set_out;

  assign accept   = s_valid_i && (state_q == ST_IDLE);
  assign out_busy = out_valid_q && !m_ready_i;

  always_comb begin
    state_d         = state_q;
    in_msg_d        = in_msg_q;
    set_out         = 1'b0;
    cmd_o.op        = rc4ks_pkg::OP_NONE;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!in_msg_q) begin
            cmd_o.op = rc4ks_pkg::OP_START;
            in_msg_d = 1'b1;
            state_d  = ST_INIT;
          end else begin
            cmd_o.op = rc4ks_pkg::OP_CAP;
            state_d  = ST_P1;
          end
        end
      end
      ST_INIT: begin
        cmd_o.op = rc4ks_pkg::OP_INIT;
        if (sts_i.cnt_last) begin
          state_d = ST_K1;
        end
      end
      ST_K1: begin
        cmd_o.op = rc4ks_pkg::OP_K1;
        state_d  = ST_K2;
      end
      ST_K2: begin
        cmd_o.op = rc4ks_pkg::OP_K2;
        state_d  = ST_K3;
      end
      ST_K3: begin
        cmd_o.op = rc4ks_pkg::OP_K3;
        state_d  = ST_K4;
      end
      ST_K4: begin
        cmd_o.op = rc4ks_pkg::OP_K4;
        state_d  = sts_i.cnt_last ? ST_P1 : ST_K1;
      end
      ST_P1: begin
        cmd_o.op = rc4ks_pkg::OP_P1;
        state_d  = ST_P2;
      end
      ST_P2: begin
        cmd_o.op = rc4ks_pkg::OP_P2;
        state_d  = ST_P3;
      end
      ST_P3: begin
        cmd_o.op = rc4ks_pkg::OP_P3;
        state_d  = ST_P4;
      end
      ST_P4: begin
        cmd_o.op = rc4ks_pkg::OP_P4;
        state_d  = ST_P5;
      end
      ST_P5: begin
        cmd_o.op = rc4ks_pkg::OP_P5;
        state_d  = ST_P6;
      end
      ST_P6: begin
        // a final word waits here until the previous checksum is taken
        if (!(sts_i.last && out_busy)) begin
          cmd_o.op       = rc4ks_pkg::OP_P6;
          cmd_o.load_out = sts_i.last;
          set_out        = sts_i.last;
          if (sts_i.last) begin
            in_msg_d = 1'b0;
          end
          state_d = ST_IDLE;
        end else begin
          // keep the keystream byte on the RAM output while waiting
          cmd_o.op = rc4ks_pkg::OP_P5;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !m_ready_i) || set_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_msg_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_msg_q    <= in_msg_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;

  `RC4KS_ASSERT_NXT(a_start_runs_sched, accept && !in_msg_q, state_q == ST_INIT && in_msg_q,
    "first word of a message must start the key schedule")
  `RC4KS_ASSERT_NXT(a_sched_to_gen, state_q == ST_K4 && sts_i.cnt_last, state_q == ST_P1,
    "key schedule must hand over to generation")
  `RC4KS_ASSERT_NXT(a_final_closes, state_q == ST_P6 && sts_i.last && !out_busy,
    !in_msg_q && out_valid_q, "final word must emit and close the message")
  `RC4KS_ASSERT_NXT(a_final_waits, state_q == ST_P6 && sts_i.last && out_busy,
    state_q == ST_P6 && out_valid_q, "final word must wait for a pending checksum")
  `RC4KS_ASSERT_NOW(a_busy_in_msg, state_q != ST_IDLE, in_msg_q,
    "work in progress outside a message")

endmodule

FILE: sv/rc4_keystream_xor_sum_unit.sv
`timescale 1ns / 1ps
// channel  | dir | signals                   | payload
// s_axis   | in  | tvalid tready tdata tlast | tdata[7:0] data_byte, tlast last_byte
// m_axis   | out | tvalid tready tdata       | tdata[31:0] checksum
//
// Each byte is an accept plus six steps on the S-box RAM (one write, one read port).
// The first byte of a message adds an S-box fill of 256 entries and the key
// schedule (four RAM steps per entry) before those steps.
// Reset is asynchronous; the S-box is not cleared, the schedule rewrites it.
// A held checksum does not block input; only a later final byte waits for it.
module rc4_keystream_xor_sum_unit #(
  parameter int unsigned KeyLength = rc4ks_pkg::KEY_LENGTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] checksum
);

  rc4ks_pkg::cmd_t cmd;
  rc4ks_pkg::sts_t sts;

  rc4ks_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .m_ready_i(m_axis_tready),
    .m_valid_o(m_axis_tvalid),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rc4ks_dp #(
    .KeyLength(KeyLength)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .byte_i    (s_axis_tdata),
    .last_i    (s_axis_tlast),
    .sts_o     (sts),
    .checksum_o(m_axis_tdata)
  );

endmodule
